### hw/rtl/sht_pkg.sv
// Shared types and constants for the smoothed hysteresis thermostat.
// No dependencies; used by the top level and sht_avg in hw/rtl.
package sht_pkg;

    localparam int DATA_W    = 12;
    localparam int CFG_IDX_W = 2;

    typedef logic signed [DATA_W-1:0] temp_t;

    // 1/16 degree units: 60, 50 and 65 degrees
    localparam temp_t RESET_TEMP = temp_t'(960);
    localparam temp_t LOW_RESET  = temp_t'(800);
    localparam temp_t HIGH_RESET = temp_t'(1040);

    localparam int TEMP_MAX = 2047;
    localparam int TEMP_MIN = -2048;

    localparam logic MODE_ADD  = 1'b0;
    localparam logic MODE_FILL = 1'b1;

    localparam logic [CFG_IDX_W-1:0] CFG_LOW_BOUND  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_HIGH_BOUND = 2'd1;

endpackage

### hw/rtl/smoothed_hysteresis_thermostat.sv
// Top level of the smoothed hysteresis thermostat.
// Depends on sht_pkg, sht_ram and sht_avg.

// One reading word is accepted every clock cycle while the output is empty or
// being taken; its result word appears on the output in the cycle after, and the
// output register holds it until taken while the next word may already be
// accepted once that slot frees. The cycle is set by the ring-sum update (one
// subtract and add on 12 + log2(WINDOW) bits), the shift and clamp, and the bound
// compare. The ring sits in a RAM whose registered read is aimed at the slot to
// be overwritten next, so the oldest sample is always on hand. A reset-smoothing
// word clears per-entry valid bits at once; an entry not written since then reads
// as the fill value. The user must write bounds on the cfg port only while idle;
// the block does not enforce it. Bounds apply only if low_bound < high_bound.
module smoothed_hysteresis_thermostat
    import sht_pkg::*;
#(
    parameter int WINDOW = 8
) (
    input  logic                 clk,
    input  logic                 rst_n,

    input  logic                 in_valid,
    output logic                 in_ready,
    input  logic                 mode,
    input  temp_t                reading,
    input  logic                 reading_valid,

    output logic                 out_valid,
    input  logic                 out_ready,
    output temp_t                latest_reading,
    output temp_t                average,
    output logic                 heating,
    output logic                 relay_changed,

    input  logic                 cfg_valid,
    output logic                 cfg_ready,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  temp_t                cfg_data
);

    localparam int SUM_W  = DATA_W + $clog2(WINDOW);
    localparam int SLOT_W = $clog2(WINDOW);
    localparam logic signed [SUM_W-1:0] SUM_RESET = SUM_W'(960 * WINDOW);

    logic                    out_valid_reg;
    logic [SLOT_W-1:0]       write_slot_reg, write_slot_next;
    logic [WINDOW-1:0]       entry_valid_reg, entry_valid_next;
    temp_t                   fill_value_reg, fill_value_next;
    logic signed [SUM_W-1:0] ring_sum_reg, ring_sum_next;
    temp_t                   smoothed_reg, smoothed_next;
    temp_t                   last_reading_reg, last_reading_next;
    logic                    relay_on_reg, relay_on_next;
    logic                    relay_changed_reg;
    temp_t                   low_bound_reg, high_bound_reg;
    temp_t                   active_low_reg, active_high_reg;

    logic                    in_accept;
    logic                    do_add;
    logic                    do_fill;
    temp_t                   ram_rdata;
    temp_t                   oldest;
    logic signed [SUM_W-1:0] sum_add;
    logic signed [SUM_W-1:0] sum_fill;
    temp_t                   avg_add;
    temp_t                   cand_low, cand_high;

    assign in_ready  = !out_valid_reg || out_ready;
    assign in_accept = in_valid && in_ready;
    assign do_add    = in_accept && reading_valid && (mode == MODE_ADD);
    assign do_fill   = in_accept && reading_valid && (mode == MODE_FILL);

    sht_ram #(
        .WIDTH (DATA_W),
        .DEPTH (WINDOW)
    ) u_ring (
        .clk   (clk),
        .we    (do_add),
        .waddr (write_slot_reg),
        .wdata (reading),
        .raddr (write_slot_next),
        .rdata (ram_rdata)
    );

    // read data always tracks ram[write_slot_reg]; stale entries use the fill value
    assign oldest   = entry_valid_reg[write_slot_reg] ? ram_rdata : fill_value_reg;
    assign sum_add  = ring_sum_reg - SUM_W'(oldest) + SUM_W'(reading);
    assign sum_fill = SUM_W'(reading) * SUM_W'(WINDOW);

    sht_avg #(
        .WINDOW (WINDOW)
    ) u_avg (
        .sum     (sum_add),
        .average (avg_add)
    );

    always_comb
    begin
        write_slot_next   = write_slot_reg;
        entry_valid_next  = entry_valid_reg;
        fill_value_next   = fill_value_reg;
        ring_sum_next     = ring_sum_reg;
        smoothed_next     = smoothed_reg;
        last_reading_next = last_reading_reg;
        if (do_add)
        begin
            write_slot_next   = (write_slot_reg == SLOT_W'(WINDOW - 1)) ?
                                '0 : write_slot_reg + SLOT_W'(1);
            entry_valid_next[write_slot_reg] = 1'b1;
            ring_sum_next     = sum_add;
            smoothed_next     = avg_add;
            last_reading_next = reading;
        end
        else if (do_fill)
        begin
            entry_valid_next  = '0;
            fill_value_next   = reading;
            ring_sum_next     = sum_fill;
            smoothed_next     = reading;
            last_reading_next = reading;
        end

        relay_on_next = relay_on_reg;
        if (relay_on_reg)
        begin
            if (smoothed_next >= active_high_reg)
            begin
                relay_on_next = 1'b0;
            end
        end
        else if (smoothed_next <= active_low_reg)
        begin
            relay_on_next = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg     <= 1'b0;
            write_slot_reg    <= '0;
            entry_valid_reg   <= '0;
            fill_value_reg    <= RESET_TEMP;
            ring_sum_reg      <= SUM_RESET;
            smoothed_reg      <= RESET_TEMP;
            last_reading_reg  <= RESET_TEMP;
            relay_on_reg      <= 1'b0;
            relay_changed_reg <= 1'b0;
        end
        else
        begin
            if (in_accept)
            begin
                out_valid_reg     <= 1'b1;
                write_slot_reg    <= write_slot_next;
                entry_valid_reg   <= entry_valid_next;
                fill_value_reg    <= fill_value_next;
                ring_sum_reg      <= ring_sum_next;
                smoothed_reg      <= smoothed_next;
                last_reading_reg  <= last_reading_next;
                relay_on_reg      <= relay_on_next;
                relay_changed_reg <= relay_on_next != relay_on_reg;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // bound registers; the active pair follows only an ordered pair
    assign cfg_ready = 1'b1;
    assign cand_low  = (cfg_index == CFG_LOW_BOUND)  ? cfg_data : low_bound_reg;
    assign cand_high = (cfg_index == CFG_HIGH_BOUND) ? cfg_data : high_bound_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            low_bound_reg   <= LOW_RESET;
            high_bound_reg  <= HIGH_RESET;
            active_low_reg  <= LOW_RESET;
            active_high_reg <= HIGH_RESET;
        end
        else if (cfg_valid && (cfg_index == CFG_LOW_BOUND || cfg_index == CFG_HIGH_BOUND))
        begin
            low_bound_reg  <= cand_low;
            high_bound_reg <= cand_high;
            if (cand_low < cand_high)
            begin
                active_low_reg  <= cand_low;
                active_high_reg <= cand_high;
            end
        end
    end

    assign out_valid      = out_valid_reg;
    assign latest_reading = last_reading_reg;
    assign average        = smoothed_reg;
    assign heating        = relay_on_reg;
    assign relay_changed  = relay_changed_reg;

`ifndef ASSERT_OFF
    a_bounds_ordered: assert property (@(posedge clk) disable iff (!rst_n)
        active_low_reg < active_high_reg)
        else $error("active bounds not ordered");

    a_slot_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        write_slot_reg <= SLOT_W'(WINDOW - 1))
        else $error("write slot past window");

    a_relay_flag: assert property (@(posedge clk) disable iff (!rst_n)
        !$stable(relay_on_reg) |-> relay_changed_reg)
        else $error("relay moved without changed flag");

    a_fill_clears: assert property (@(posedge clk) disable iff (!rst_n)
        do_fill |=> (entry_valid_reg == '0) && (ring_sum_reg == $past(sum_fill)))
        else $error("fill did not reset ring state");
`endif

endmodule

### hw/rtl/sht_ram.sv
// Generic single-port-write, single-port-read RAM with registered read data.
// No dependencies.
module sht_ram #(
    parameter int WIDTH = 12,
    parameter int DEPTH = 8
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

### hw/rtl/sht_avg.sv
// Moving average from the ring sum: arithmetic shift (floor) and clamp.
// Depends on sht_pkg.
module sht_avg
    import sht_pkg::*;
#(
    parameter int WINDOW = 8
) (
    input  logic signed [DATA_W+$clog2(WINDOW)-1:0] sum,
    output temp_t                                   average
);

    localparam int SUM_W = DATA_W + $clog2(WINDOW);
    localparam int SHIFT = $clog2(WINDOW + 1) - 1;
    localparam logic signed [SUM_W-1:0] AVG_MAX = SUM_W'(TEMP_MAX);
    localparam logic signed [SUM_W-1:0] AVG_MIN = SUM_W'(TEMP_MIN);

    logic signed [SUM_W-1:0] shifted;

    // clamp only bites when the window is not a power of two
    always_comb
    begin
        shifted = sum >>> SHIFT;
        if (shifted > AVG_MAX)
        begin
            average = temp_t'(TEMP_MAX);
        end
        else if (shifted < AVG_MIN)
        begin
            average = temp_t'(TEMP_MIN);
        end
        else
        begin
            average = shifted[DATA_W-1:0];
        end
    end

endmodule
